// ===== design/float_fixed_point_converter_macros.svh =====
// assertion macros for the float/fixed converter
`ifndef FLOAT_FIXED_POINT_CONVERTER_MACROS_SVH
`define FLOAT_FIXED_POINT_CONVERTER_MACROS_SVH
`ifndef SYNTH
`define FFC_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("label");
`define FFC_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("label");
`else
`define FFC_ASSERT_IMP(label, clk, rst, a, c)
`define FFC_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ===== design/ffc_pkg.sv =====
// ============================================================================
// ffc_pkg
// shared types and constants of the float/fixed converter
// ============================================================================
package ffc_pkg;
   localparam int unsigned FRAC_W = 5;
   localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd8;
   localparam logic [FRAC_W-1:0] FRAC_MAX = 5'd30;
   localparam int unsigned ADDR_W = 1;
   localparam logic [ADDR_W-1:0] REG_FRAC_BITS = 1'b0;

   localparam logic [1:0] ST_EXACT   = 2'd0;
   localparam logic [1:0] ST_INEXACT = 2'd1;
   localparam logic [1:0] ST_SAT     = 2'd2;
   localparam logic [1:0] ST_NAN     = 2'd3;

   localparam logic REQ_F2X = 1'b0;
   localparam logic REQ_X2F = 1'b1;

   // decoded operand after stage 1
   typedef struct packed {
      logic        valid;
      logic        kind;
      logic        neg;
      logic        is_nan;
      logic        is_inf;
      logic        is_zero;
      logic [23:0] mant;
      logic [8:0]  shamt;
      logic        left;
      logic [31:0] mag;
      logic [4:0]  lz;
      logic [4:0]  n;
   } s1_type;

   // shifted value after stage 2
   typedef struct packed {
      logic        valid;
      logic        kind;
      logic        neg;
      logic        special_nan;
      logic        sat;
      logic        is_zero;
      logic [31:0] val;
      logic        sticky;
      logic        guard;
      logic [7:0]  bexp;
   } s2_type;
endpackage

// ===== design/ffc_csr.sv =====
// ============================================================================
// ffc_csr
// configuration register file holding the fraction bit count
// ============================================================================
module ffc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ffc_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output logic [ffc_pkg::FRAC_W-1:0]  frac_n
);
   import ffc_pkg::*;

   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite && (paddr == REG_FRAC_BITS);

   always_comb begin
      frac_in = frac_ff;
      if (wr) begin
         frac_in = pwdata[FRAC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff <= FRAC_RESET;
      end else begin
         frac_ff <= frac_in;
      end
   end

   assign prdata = (paddr == REG_FRAC_BITS) ? {{(32-FRAC_W){1'b0}}, frac_ff} : 32'd0;
   assign frac_n = (frac_ff > FRAC_MAX) ? FRAC_MAX : frac_ff;
endmodule

// ===== design/ffc_decode.sv =====
// ============================================================================
// ffc_decode
// stage 1: field split, exponent arithmetic, magnitude and leading zeros
// ============================================================================
module ffc_decode (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic                        kind,
   input  logic [31:0]                 operand,
   input  logic [ffc_pkg::FRAC_W-1:0]  frac_n,
   output ffc_pkg::s1_type             s1
);
   import ffc_pkg::*;

   s1_type s1_ff, s1_in;
   logic [7:0]  bexp;
   logic [22:0] frac;
   logic signed [10:0] e;
   logic [31:0] mag;
   logic [4:0] lz;

   always_comb begin
      bexp = operand[30:23];
      frac = operand[22:0];
      e = $signed({3'b000, (bexp == 8'd0) ? 8'd1 : bexp}) - 11'sd150
          + $signed({6'b0, frac_n});
      mag = operand[31] ? (32'd0 - operand) : operand;
      lz = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (mag[i]) begin
            lz = 5'(31 - i);
         end
      end
      s1_in.valid   = in_valid;
      s1_in.kind    = kind;
      s1_in.neg     = operand[31];
      s1_in.is_nan  = (bexp == 8'hFF) && (frac != 23'd0);
      s1_in.is_inf  = (bexp == 8'hFF) && (frac == 23'd0);
      s1_in.mant    = {(bexp != 8'd0), frac};
      s1_in.left    = !e[10];
      s1_in.shamt   = e[10] ? 9'(-e) : e[8:0];
      s1_in.mag     = mag;
      s1_in.lz      = lz;
      s1_in.n       = frac_n;
      s1_in.is_zero = (kind == REQ_F2X) ? (s1_in.mant == 24'd0) : (mag == 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid <= s1_in.valid;
      end
      s1_ff.kind    <= s1_in.kind;
      s1_ff.neg     <= s1_in.neg;
      s1_ff.is_nan  <= s1_in.is_nan;
      s1_ff.is_inf  <= s1_in.is_inf;
      s1_ff.is_zero <= s1_in.is_zero;
      s1_ff.mant    <= s1_in.mant;
      s1_ff.shamt   <= s1_in.shamt;
      s1_ff.left    <= s1_in.left;
      s1_ff.mag     <= s1_in.mag;
      s1_ff.lz      <= s1_in.lz;
      s1_ff.n       <= s1_in.n;
   end

   assign s1 = s1_ff;
endmodule

// ===== design/ffc_shift.sv =====
// ============================================================================
// ffc_shift
// stage 2: barrel shift for both directions, range check, guard and sticky
// ============================================================================
module ffc_shift (
   input  logic            clock,
   input  logic            reset,
   input  ffc_pkg::s1_type s1,
   output ffc_pkg::s2_type s2
);
   import ffc_pkg::*;

   s2_type s2_ff, s2_in;
   logic [63:0] wide;
   logic [63:0] rmask;
   logic [31:0] norm;
   logic [7:0]  p;

   always_comb begin
      wide = 64'd0;
      rmask = 64'd0;
      norm = s1.mag << s1.lz;
      p = 8'd31 - {3'b000, s1.lz};
      s2_in = '0;
      s2_in.valid = s1.valid;
      s2_in.kind  = s1.kind;
      s2_in.neg   = s1.neg;
      s2_in.is_zero = s1.is_zero;
      if (s1.kind == REQ_F2X) begin
         s2_in.special_nan = s1.is_nan;
         if (s1.is_inf) begin
            s2_in.sat = 1'b1;
         end else if (s1.is_zero) begin
            s2_in.val = 32'd0;
         end else if (s1.left) begin
            if (s1.shamt >= 9'd9) begin
               s2_in.sat = 1'b1;
            end else begin
               wide = {40'd0, s1.mant} << s1.shamt[3:0];
               s2_in.val = wide[31:0];
            end
         end else begin
            if (s1.shamt >= 9'd24) begin
               s2_in.val = 32'd0;
               s2_in.sticky = 1'b1;
            end else begin
               wide = {40'd0, s1.mant} >> s1.shamt[4:0];
               rmask = (64'd1 << s1.shamt[4:0]) - 64'd1;
               s2_in.val = wide[31:0];
               s2_in.sticky = ({40'd0, s1.mant} & rmask) != 64'd0;
            end
         end
         if (!s2_in.sat && !s1.is_inf) begin
            if (s1.neg ? (s2_in.val > 32'h8000_0000) : (s2_in.val > 32'h7FFF_FFFF)) begin
               s2_in.sat = 1'b1;
            end
         end
      end else begin
         // norm[31] is the leading one; keep 24 bits, guard, sticky
         s2_in.val = {8'd0, norm[31:8]};
         s2_in.guard = norm[7];
         s2_in.sticky = norm[6:0] != 7'd0;
         s2_in.bexp = p + 8'd127 - {3'b000, s1.n};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else begin
         s2_ff.valid <= s2_in.valid;
      end
      s2_ff.kind        <= s2_in.kind;
      s2_ff.neg         <= s2_in.neg;
      s2_ff.special_nan <= s2_in.special_nan;
      s2_ff.sat         <= s2_in.sat;
      s2_ff.is_zero     <= s2_in.is_zero;
      s2_ff.val         <= s2_in.val;
      s2_ff.sticky      <= s2_in.sticky;
      s2_ff.guard       <= s2_in.guard;
      s2_ff.bexp        <= s2_in.bexp;
   end

   assign s2 = s2_ff;
endmodule

// ===== design/ffc_round.sv =====
// ============================================================================
// ffc_round
// stage 3: rounding, negation, saturation and packing of the result
// ============================================================================
module ffc_round (
   input  logic            clock,
   input  logic            reset,
   input  ffc_pkg::s2_type s2,
   output logic            out_valid,
   output logic [31:0]     out_bits,
   output logic [1:0]      out_status
);
   import ffc_pkg::*;

   logic        valid_ff, valid_in;
   logic [31:0] bits_ff, bits_in;
   logic [1:0]  st_ff, st_in;
   logic [24:0] m;
   logic [7:0]  be;
   logic        up;

   always_comb begin
      valid_in = s2.valid;
      bits_in = 32'd0;
      st_in = ST_EXACT;
      up = s2.guard && (s2.sticky || s2.val[0]);
      m = {1'b0, s2.val[23:0]} + {24'd0, up};
      be = s2.bexp;
      if (m[24]) begin
         be = s2.bexp + 8'd1;
      end
      if (s2.kind == REQ_F2X) begin
         if (s2.special_nan) begin
            st_in = ST_NAN;
         end else if (s2.sat) begin
            bits_in = s2.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            st_in = ST_SAT;
         end else begin
            bits_in = s2.neg ? (32'd0 - s2.val) : s2.val;
            st_in = s2.sticky ? ST_INEXACT : ST_EXACT;
         end
      end else if (!s2.is_zero) begin
         bits_in = {s2.neg, be, m[24] ? m[23:1] : m[22:0]};
         st_in = (s2.guard || s2.sticky) ? ST_INEXACT : ST_EXACT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      bits_ff <= bits_in;
      st_ff <= st_in;
   end

   assign out_valid = valid_ff;
   assign out_bits = bits_ff;
   assign out_status = st_ff;
endmodule

// ===== design/float_fixed_point_converter.sv =====
// ============================================================================
// float_fixed_point_converter
// IEEE single <-> 32-bit Qm.n fixed point, three-stage pipeline
// ============================================================================
// A request is taken in every cycle (busy stays low) and its result appears on
// the rsp_ ports with rsp_valid high for one cycle, after passing the three
// register stages (decode, shift, round). The
// receiver cannot stall. Write frac_bits only while no request is in flight.
`include "float_fixed_point_converter_macros.svh"
module float_fixed_point_converter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_type,
   input  logic [31:0]                req_operand_bits,
   output logic                       rsp_valid,
   output logic [31:0]                rsp_result_bits,
   output logic [1:0]                 rsp_status,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ffc_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import ffc_pkg::*;

   logic [FRAC_W-1:0] frac_n;
   s1_type s1;
   s2_type s2;

   assign busy = 1'b0;

   ffc_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .frac_n(frac_n)
   );

   ffc_decode u_decode (
      .clock(clock), .reset(reset), .in_valid(start && !busy), .kind(req_type),
      .operand(req_operand_bits), .frac_n(frac_n), .s1(s1)
   );

   ffc_shift u_shift (.clock(clock), .reset(reset), .s1(s1), .s2(s2));

   ffc_round u_round (
      .clock(clock), .reset(reset), .s2(s2), .out_valid(rsp_valid),
      .out_bits(rsp_result_bits), .out_status(rsp_status)
   );

   `FFC_ASSERT_NXT(a_start_flows, clock, reset, start, s1.valid)
   `FFC_ASSERT_NXT(a_s1_flows, clock, reset, s1.valid, s2.valid)
   `FFC_ASSERT_NXT(a_s2_flows, clock, reset, s2.valid, rsp_valid)
   `FFC_ASSERT_IMP(a_x2f_no_sat, clock, reset, rsp_valid && $past(s2.kind) == REQ_X2F, rsp_status != ST_SAT && rsp_status != ST_NAN)
endmodule

// ===== sim/float_fixed_point_converter_tb.sv =====
// ============================================================================
// float_fixed_point_converter_tb
// checks float/fixed conversions against a predictor over several frac_bits
// settings, with bursty requests, directed corner cases and random operands
// ============================================================================
module float_fixed_point_converter_tb;
   import ffc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   class conv_scoreboard;
      logic [31:0] want_bits[$];
      logic [1:0]  want_status[$];
      int          errors;

      function void note_request(logic kind, logic [31:0] op, logic [4:0] n);
         logic [31:0] r;
         logic [1:0]  s;
         predict(kind, op, n, r, s);
         want_bits.push_back(r);
         want_status.push_back(s);
      endfunction

      function void check_result(logic [31:0] bits, logic [1:0] st);
         logic [31:0] eb;
         logic [1:0]  es;
         if (want_bits.size() == 0) begin
            $error("unexpected result %h status %0d", bits, st);
            errors++;
            return;
         end
         eb = want_bits.pop_front();
         es = want_status.pop_front();
         if (bits !== eb) begin
            $error("result_bits expected %h actual %h", eb, bits);
            errors++;
         end
         if (st !== es) begin
            $error("status expected %0d actual %0d", es, st);
            errors++;
         end
      endfunction

      function void predict(logic kind, logic [31:0] op, logic [4:0] nreg,
                            output logic [31:0] r, output logic [1:0] s);
         int          n, e, sh, p;
         logic [7:0]  bexp;
         logic [63:0] mant, mag;
         logic [31:0] xm, rem, half, m;
         logic        neg, inexact, sat;
         n = (nreg > FRAC_MAX) ? FRAC_MAX : nreg;
         neg = op[31];
         inexact = 0;
         sat = 0;
         mag = 0;
         if (kind == REQ_F2X) begin
            bexp = op[30:23];
            if (bexp == 8'hFF && op[22:0] != 0) begin
               r = 0; s = ST_NAN; return;
            end
            if (bexp == 8'hFF) sat = 1;
            else begin
               mant = (bexp == 0) ? {41'd0, op[22:0]} : {40'd0, 1'b1, op[22:0]};
               e = ((bexp == 0) ? 1 : int'(bexp)) - 150 + n;
               if (mant == 0) mag = 0;
               else if (e >= 0) begin
                  if (e >= 40) sat = 1;
                  else mag = mant << e;
               end else begin
                  sh = -e;
                  if (sh >= 64) begin mag = 0; inexact = 1; end
                  else begin
                     mag = mant >> sh;
                     inexact = (mant & ((64'd1 << sh) - 1)) != 0;
                  end
               end
               if (!sat && (neg ? mag > 64'h80000000 : mag > 64'h7FFFFFFF)) sat = 1;
            end
            if (sat) begin
               r = neg ? 32'h80000000 : 32'h7FFFFFFF; s = ST_SAT; return;
            end
            r = neg ? 32'(-mag[31:0]) : mag[31:0];
            s = inexact ? ST_INEXACT : ST_EXACT;
         end else begin
            xm = neg ? -op : op;
            if (xm == 0) begin r = 0; s = ST_EXACT; return; end
            p = 31;
            while (xm[p] == 0) p--;
            if (p > 23) begin
               sh = p - 23;
               rem = xm & ((32'd1 << sh) - 1);
               half = 32'd1 << (sh - 1);
               m = xm >> sh;
               inexact = rem != 0;
               if (rem > half || (rem == half && m[0])) m++;
               if (m == 32'h1000000) begin m = m >> 1; p++; end
            end else m = xm << (23 - p);
            r = {neg, 8'(p + 127 - n), m[22:0]};
            s = inexact ? ST_INEXACT : ST_EXACT;
         end
      endfunction
   endclass

   logic        clock = 0, reset = 1, start = 0, req_type = 0;
   logic [31:0] req_operand_bits = 0;
   logic        busy, rsp_valid, pready;
   logic [31:0] rsp_result_bits, prdata;
   logic [1:0]  rsp_status;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [ADDR_W-1:0] paddr = 0;
   logic [31:0] pwdata = 0;
   logic [4:0]  frac_now = FRAC_RESET;
   int          idle_cycles = 0;
   conv_scoreboard board = new();

   float_fixed_point_converter i_dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_result_bits, rsp_status);
      if ((start && !busy) || rsp_valid || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send(logic kind, logic [31:0] op);
      start <= 1;
      req_type <= kind;
      req_operand_bits <= op;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(kind, op, frac_now);
   endtask

   task automatic pause_gap();
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clock);
   endtask

   task automatic drain();
      start <= 0;
      while (board.want_bits.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_frac(logic [4:0] v);
      psel <= 1; pwrite <= 1; paddr <= REG_FRAC_BITS; pwdata <= {27'd0, v};
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      frac_now = v;
   endtask

   function automatic logic [31:0] rand_float();
      case ($urandom_range(0, 5))
         0: return {$urandom_range(0, 1) == 1, 8'($urandom_range(118, 162)),
                    23'($urandom)};
         1: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(0, 1))};
         2: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
         3: return {$urandom_range(0, 1) == 1, 8'($urandom_range(150, 160)),
                    23'(0)};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_fixed();
      case ($urandom_range(0, 3))
         0: return 32'($urandom_range(0, 300)) - 32'd150;
         1: return $urandom >> $urandom_range(0, 31);
         2: return {$urandom_range(0, 1) == 1, 31'd0} | (32'd1 << $urandom_range(0, 30));
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [4:0] settings[6];
      int burst;
      settings = '{5'd0, 5'd30, 5'd31, 5'd8, 5'd16, 5'd1};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(REQ_F2X, 32'h0000_0000); send(REQ_F2X, 32'h8000_0000);
      send(REQ_F2X, 32'h7F80_0000); send(REQ_F2X, 32'hFF80_0000);
      send(REQ_F2X, 32'h7FC0_0001); send(REQ_F2X, 32'hFFFF_FFFF);
      send(REQ_F2X, 32'h0000_0001); send(REQ_F2X, 32'h807F_FFFF);
      send(REQ_F2X, 32'h3F80_0000); send(REQ_F2X, 32'hBFC0_0000);
      send(REQ_F2X, 32'h4EFF_FFFF); send(REQ_F2X, 32'hCF00_0000);
      send(REQ_F2X, 32'hCF00_0001); send(REQ_F2X, 32'h7F7F_FFFF);
      send(REQ_X2F, 32'h0000_0000); send(REQ_X2F, 32'h8000_0000);
      send(REQ_X2F, 32'h7FFF_FFFF); send(REQ_X2F, 32'h0000_0001);
      send(REQ_X2F, 32'hFFFF_FFFF); send(REQ_X2F, 32'h0100_0001);
      send(REQ_X2F, 32'h0100_0003); send(REQ_X2F, 32'h01FF_FFFF);
      drain();
      foreach (settings[i]) begin
         write_frac(settings[i]);
         for (int k = 0; k < 135; k += burst) begin
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst; j++) begin
               if ($urandom_range(0, 1)) send(REQ_F2X, rand_float());
               else send(REQ_X2F, rand_fixed());
            end
            if ($urandom_range(0, 2) != 0) pause_gap();
         end
         drain();
      end
      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.want_bits.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
